@@ hdl/brcs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brcs_pkg - shared constants of the blit rectangle clip setup
// Bit positions of the fixed-width fields at the bottom of the result word.
// ----------------------------------------------------------------------------
package brcs_pkg;

  // result word: flags first, then the corner and offset fields
  localparam int unsigned EMPTY_BIT  = 0;
  localparam int unsigned DESC_BIT   = 1;
  localparam int unsigned FIELD_BASE = 2;

  // number of registers from the slave port to the master port
  localparam int unsigned PIPE_STAGES = 4;

endpackage

@@ hdl/blit_rectangle_clip_setup.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blit_rectangle_clip_setup - clip a blit rectangle to source and destination
// Clips the rectangle to the source frame, then to the destination frame,
// moving the matching corner of the other rectangle each time, and computes the start offsets.
// ----------------------------------------------------------------------------
//
//  channel  | direction | contents
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | blit request: frame sizes, positions, size, direction
//  m_axis   | out       | clipped corners, empty flag, direction, start offsets
//
//  One request enters per cycle while s_axis_tready is high; its result
//  reaches m_axis through the input register, source clip, destination
//  clip, then empty check and the row-times-stride multiply.
//  Reset clears the stage valid bits only; payload registers hold garbage.
//  A stall on m_axis holds each full stage with no empty stage after it;
//  s_axis_tready drops only when all four registers hold a request.
//
module blit_rectangle_clip_setup
  import brcs_pkg::*;
#(
  parameter int unsigned DIM_BITS = 12
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // s_axis_tdata, lowest bit up: dest_stride, dest_rows, dest_pos_x,
  // dest_pos_y, rect_width, rect_height, src_stride, src_rows, src_pos_x,
  // src_pos_y, dest_below_src, zero fill
  input  logic [((10*DIM_BITS+9+7)/8)*8-1:0] s_axis_tdata,

  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // m_axis_tdata, lowest bit up: empty_res, descending, src_x_first,
  // src_y_first, src_x_last, src_y_last, dst_x_first, dst_y_first,
  // dst_x_last, dst_y_last, src_start_offset, dst_start_offset, zero fill
  output logic [((12*DIM_BITS+2+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned D         = DIM_BITS;
  localparam int unsigned POS_BITS  = D + 2;
  localparam int unsigned WORK_BITS = D + 5;   // holds every intermediate corner
  localparam int unsigned OFS_BITS  = 2 * D;
  localparam int unsigned IN_BITS   = 10 * D + 9;
  localparam int unsigned OUT_W     = ((12 * D + 2 + 7) / 8) * 8;

  // field positions in the request word
  localparam int unsigned DW_LSB  = 0;
  localparam int unsigned DH_LSB  = D;
  localparam int unsigned DX_LSB  = 2 * D;
  localparam int unsigned DY_LSB  = 2 * D + POS_BITS;
  localparam int unsigned W_LSB   = 2 * D + 2 * POS_BITS;
  localparam int unsigned H_LSB   = 3 * D + 2 * POS_BITS;
  localparam int unsigned SW_LSB  = 4 * D + 2 * POS_BITS;
  localparam int unsigned SH_LSB  = 5 * D + 2 * POS_BITS;
  localparam int unsigned SX_LSB  = 6 * D + 2 * POS_BITS;
  localparam int unsigned SY_LSB  = 6 * D + 3 * POS_BITS;
  localparam int unsigned ASC_BIT = 6 * D + 4 * POS_BITS;

  localparam logic signed [WORK_BITS-1:0] ZERO_W = WORK_BITS'(0);
  localparam logic signed [WORK_BITS-1:0] ONE_W  = WORK_BITS'(1);

  typedef logic signed [WORK_BITS-1:0] crd_t;

  // corners and frame sizes carried between the clip stages
  typedef struct packed {
    crd_t         sx0;
    crd_t         sy0;
    crd_t         sx1;
    crd_t         sy1;
    crd_t         dx0;
    crd_t         dy0;
    crd_t         dx1;
    crd_t         dy1;
    crd_t         sw;
    crd_t         sh;
    crd_t         dw;
    crd_t         dh;
    logic         zero_sz;
    logic         asc;
  } clip_t;

  function automatic crd_t ext_u(input logic [D-1:0] v);
    return $signed({{(WORK_BITS - D){1'b0}}, v});
  endfunction

  function automatic crd_t ext_s(input logic [POS_BITS-1:0] v);
    return $signed({{(WORK_BITS - POS_BITS){v[POS_BITS-1]}}, v});
  endfunction

  // --------------------------------------------------------------------------
  // Flow control: a stage advances when it is empty or the next one advances
  // --------------------------------------------------------------------------
  logic         v0_q, v1_q, v2_q, v3_q;
  logic         adv0, adv1, adv2, adv3;

  logic [IN_BITS-1:0] req_q;
  clip_t              c1_d, c1_q;
  clip_t              c2_d, c2_q;
  logic [OUT_W-1:0]   res_d, res_q;

  assign adv3 = !v3_q || m_axis_tready;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign adv0 = !v0_q || adv1;

  assign s_axis_tready = adv0;
  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv0) v0_q <= s_axis_tvalid;
      if (adv1) v1_q <= v0_q;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv0) req_q <= s_axis_tdata[IN_BITS-1:0];
    if (adv1) c1_q  <= c1_d;
    if (adv2) c2_q  <= c2_d;
    if (adv3) res_q <= res_d;
  end

  // --------------------------------------------------------------------------
  // Stage 1: form the far corners, clip to the source frame
  // --------------------------------------------------------------------------
  always_comb begin
    crd_t w_e, h_e;
    w_e = ext_u(req_q[W_LSB +: D]);
    h_e = ext_u(req_q[H_LSB +: D]);

    c1_d.dw      = ext_u(req_q[DW_LSB +: D]);
    c1_d.dh      = ext_u(req_q[DH_LSB +: D]);
    c1_d.sw      = ext_u(req_q[SW_LSB +: D]);
    c1_d.sh      = ext_u(req_q[SH_LSB +: D]);
    c1_d.zero_sz = (req_q[W_LSB +: D] == '0) || (req_q[H_LSB +: D] == '0);
    c1_d.asc     = req_q[ASC_BIT];

    c1_d.sx0 = ext_s(req_q[SX_LSB +: POS_BITS]);
    c1_d.sy0 = ext_s(req_q[SY_LSB +: POS_BITS]);
    c1_d.dx0 = ext_s(req_q[DX_LSB +: POS_BITS]);
    c1_d.dy0 = ext_s(req_q[DY_LSB +: POS_BITS]);
    c1_d.sx1 = c1_d.sx0 + w_e - ONE_W;
    c1_d.sy1 = c1_d.sy0 + h_e - ONE_W;
    c1_d.dx1 = c1_d.dx0 + w_e - ONE_W;
    c1_d.dy1 = c1_d.dy0 + h_e - ONE_W;

    // pull the near corner in, shift the destination by the same amount
    if ($signed(c1_d.sx0) < $signed(ZERO_W)) begin
      c1_d.dx0 = c1_d.dx0 - c1_d.sx0;
      c1_d.sx0 = ZERO_W;
    end
    if ($signed(c1_d.sy0) < $signed(ZERO_W)) begin
      c1_d.dy0 = c1_d.dy0 - c1_d.sy0;
      c1_d.sy0 = ZERO_W;
    end
    // pull the far corner in to the last column / row
    if ($signed(c1_d.sx1) >= $signed(c1_d.sw)) begin
      c1_d.dx1 = c1_d.dx1 - c1_d.sx1 + c1_d.sw - ONE_W;
      c1_d.sx1 = c1_d.sw - ONE_W;
    end
    if ($signed(c1_d.sy1) >= $signed(c1_d.sh)) begin
      c1_d.dy1 = c1_d.dy1 - c1_d.sy1 + c1_d.sh - ONE_W;
      c1_d.sy1 = c1_d.sh - ONE_W;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: clip to the destination frame, shift the source to match
  // --------------------------------------------------------------------------
  always_comb begin
    c2_d = c1_q;
    if ($signed(c1_q.dx0) < $signed(ZERO_W)) begin
      c2_d.sx0 = c1_q.sx0 - c1_q.dx0;
      c2_d.dx0 = ZERO_W;
    end
    if ($signed(c1_q.dy0) < $signed(ZERO_W)) begin
      c2_d.sy0 = c1_q.sy0 - c1_q.dy0;
      c2_d.dy0 = ZERO_W;
    end
    if ($signed(c1_q.dx1) >= $signed(c1_q.dw)) begin
      c2_d.sx1 = c1_q.sx1 - c1_q.dx1 + c1_q.dw - ONE_W;
      c2_d.dx1 = c1_q.dw - ONE_W;
    end
    if ($signed(c1_q.dy1) >= $signed(c1_q.dh)) begin
      c2_d.sy1 = c1_q.sy1 - c1_q.dy1 + c1_q.dh - ONE_W;
      c2_d.dy1 = c1_q.dh - ONE_W;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: empty check, start offsets, pack the result word
  // --------------------------------------------------------------------------
  logic                empty;
  logic [D-1:0]        src_row, src_col, dst_row, dst_col;
  logic [OFS_BITS-1:0] src_ofs, dst_ofs;

  always_comb begin
    empty = c2_q.zero_sz
         || ($signed(c2_q.sx1) < $signed(ZERO_W)) || ($signed(c2_q.sx0) >= $signed(c2_q.sw))
         || ($signed(c2_q.sy1) < $signed(ZERO_W)) || ($signed(c2_q.sy0) >= $signed(c2_q.sh))
         || ($signed(c2_q.dx1) < $signed(ZERO_W)) || ($signed(c2_q.dx0) >= $signed(c2_q.dw))
         || ($signed(c2_q.dy1) < $signed(ZERO_W)) || ($signed(c2_q.dy0) >= $signed(c2_q.dh))
         || ($signed(c2_q.sx0) > $signed(c2_q.sx1)) || ($signed(c2_q.sy0) > $signed(c2_q.sy1))
         || ($signed(c2_q.dx0) > $signed(c2_q.dx1)) || ($signed(c2_q.dy0) > $signed(c2_q.dy1));
  end

  // ascending starts at the top-left pixel, descending at the bottom-right
  assign src_row = c2_q.asc ? c2_q.sy0[D-1:0] : c2_q.sy1[D-1:0];
  assign src_col = c2_q.asc ? c2_q.sx0[D-1:0] : c2_q.sx1[D-1:0];
  assign dst_row = c2_q.asc ? c2_q.dy0[D-1:0] : c2_q.dy1[D-1:0];
  assign dst_col = c2_q.asc ? c2_q.dx0[D-1:0] : c2_q.dx1[D-1:0];

  assign src_ofs = ({{D{1'b0}}, src_row} * {{D{1'b0}}, c2_q.sw[D-1:0]})
                 + {{D{1'b0}}, src_col};
  assign dst_ofs = ({{D{1'b0}}, dst_row} * {{D{1'b0}}, c2_q.dw[D-1:0]})
                 + {{D{1'b0}}, dst_col};

  always_comb begin
    res_d            = '0;
    res_d[EMPTY_BIT] = empty;
    if (!empty) begin
      res_d[DESC_BIT]                      = !c2_q.asc;
      res_d[FIELD_BASE + 0 * D +: D]        = c2_q.sx0[D-1:0];
      res_d[FIELD_BASE + 1 * D +: D]        = c2_q.sy0[D-1:0];
      res_d[FIELD_BASE + 2 * D +: D]        = c2_q.sx1[D-1:0];
      res_d[FIELD_BASE + 3 * D +: D]        = c2_q.sy1[D-1:0];
      res_d[FIELD_BASE + 4 * D +: D]        = c2_q.dx0[D-1:0];
      res_d[FIELD_BASE + 5 * D +: D]        = c2_q.dy0[D-1:0];
      res_d[FIELD_BASE + 6 * D +: D]        = c2_q.dx1[D-1:0];
      res_d[FIELD_BASE + 7 * D +: D]        = c2_q.dy1[D-1:0];
      res_d[FIELD_BASE + 8 * D +: OFS_BITS]  = src_ofs;
      res_d[FIELD_BASE + 10 * D +: OFS_BITS] = dst_ofs;
    end
  end

endmodule

@@ hdl/brcs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brcs_checker - port-level checks of the blit rectangle clip setup
// Watches the result stream for stalls and for consistent clipped corners.
// ----------------------------------------------------------------------------
module brcs_checker
  import brcs_pkg::*;
#(
  parameter int unsigned DIM_BITS = 12
) (
  input logic clk_i,
  input logic rst_ni,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [((12*DIM_BITS+2+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned D     = DIM_BITS;
  localparam int unsigned OUT_W = ((12 * D + 2 + 7) / 8) * 8;

  logic         res_empty;
  logic [D-1:0] sxf, syf, sxl, syl, dxf, dyf, dxl, dyl;

  assign res_empty = m_axis_tdata[EMPTY_BIT];
  assign sxf = m_axis_tdata[FIELD_BASE + 0 * D +: D];
  assign syf = m_axis_tdata[FIELD_BASE + 1 * D +: D];
  assign sxl = m_axis_tdata[FIELD_BASE + 2 * D +: D];
  assign syl = m_axis_tdata[FIELD_BASE + 3 * D +: D];
  assign dxf = m_axis_tdata[FIELD_BASE + 4 * D +: D];
  assign dyf = m_axis_tdata[FIELD_BASE + 5 * D +: D];
  assign dxl = m_axis_tdata[FIELD_BASE + 6 * D +: D];
  assign dyl = m_axis_tdata[FIELD_BASE + 7 * D +: D];

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // an empty result carries nothing else
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_empty |-> m_axis_tdata[OUT_W-1:DESC_BIT] == '0)
    else $error("empty result with nonzero fields");

  // clipped corners are ordered
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res_empty |-> sxf <= sxl && syf <= syl && dxf <= dxl && dyf <= dyl)
    else $error("clipped corners out of order");

  // both rectangles keep the same size after clipping
  a_same_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res_empty
      |-> D'(sxl - sxf) == D'(dxl - dxf) && D'(syl - syf) == D'(dyl - dyf))
    else $error("source and destination sizes differ");

  // no result is shown in the cycle that follows reset
  a_reset_clear: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind blit_rectangle_clip_setup brcs_checker #(.DIM_BITS(DIM_BITS)) u_brcs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ tb/tb_blit_rectangle_clip_setup.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_blit_rectangle_clip_setup - self-checking bench for the blit clip setup
// Drives blit requests on the slave stream and predicts every clipped result
// in a scoreboard. The bench runs directed corner cases first, then random
// requests under three idle mixes, a long output hold-off and a full drain.
// ----------------------------------------------------------------------------
module tb_blit_rectangle_clip_setup
  import brcs_pkg::*;
();

  localparam int unsigned DIM_BITS    = 12;
  localparam int unsigned POS_W       = DIM_BITS + 2;
  localparam int unsigned OFS_W       = 2 * DIM_BITS;
  localparam int unsigned S_W         = ((10*DIM_BITS+9+7)/8)*8;
  localparam int unsigned M_W         = ((12*DIM_BITS+2+7)/8)*8;
  localparam int unsigned RES_W       = 8*DIM_BITS + 2*OFS_W + 2;
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned PHASE_ITEMS = 343;

  // One blit request as it travels on s_axis_tdata.
  typedef struct {
    bit        [DIM_BITS-1:0] dst_stride;
    bit        [DIM_BITS-1:0] dst_rows;
    bit signed [POS_W-1:0]    dst_pos_x;
    bit signed [POS_W-1:0]    dst_pos_y;
    bit        [DIM_BITS-1:0] rect_w;
    bit        [DIM_BITS-1:0] rect_h;
    bit        [DIM_BITS-1:0] src_stride;
    bit        [DIM_BITS-1:0] src_rows;
    bit signed [POS_W-1:0]    src_pos_x;
    bit signed [POS_W-1:0]    src_pos_y;
    bit                       dest_below_src;
  } blit_req_t;

  // Clipped result; listed from the top bit down, so is_empty lands in bit 0.
  typedef struct packed {
    bit [OFS_W-1:0]    dst_ofs;
    bit [OFS_W-1:0]    src_ofs;
    bit [DIM_BITS-1:0] dst_y_last;
    bit [DIM_BITS-1:0] dst_x_last;
    bit [DIM_BITS-1:0] dst_y_first;
    bit [DIM_BITS-1:0] dst_x_first;
    bit [DIM_BITS-1:0] src_y_last;
    bit [DIM_BITS-1:0] src_x_last;
    bit [DIM_BITS-1:0] src_y_first;
    bit [DIM_BITS-1:0] src_x_first;
    bit                descending;
    bit                is_empty;
  } clip_res_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the clipped rectangle of each accepted request and
  // matches results against the oldest prediction.
  // --------------------------------------------------------------------------
  class clip_scoreboard;
    clip_res_t   pending_q[$];
    int unsigned mismatches;

    function clip_res_t clip_rect(blit_req_t r);
      clip_res_t res;
      longint dw, dh, sw, sh, w, h;
      longint sx0, sy0, sx1, sy1, dx0, dy0, dx1, dy1;
      bit     none_left;
      res = '0;
      dw  = longint'(r.dst_stride);
      dh  = longint'(r.dst_rows);
      sw  = longint'(r.src_stride);
      sh  = longint'(r.src_rows);
      w   = longint'(r.rect_w);
      h   = longint'(r.rect_h);
      dx0 = longint'(r.dst_pos_x);
      dy0 = longint'(r.dst_pos_y);
      sx0 = longint'(r.src_pos_x);
      sy0 = longint'(r.src_pos_y);
      if (w == 0 || h == 0) begin
        res.is_empty = 1'b1;
        return res;
      end
      sx1 = sx0 + w - 1;
      sy1 = sy0 + h - 1;
      dx1 = dx0 + w - 1;
      dy1 = dy0 + h - 1;
      // source frame first, dragging the destination corners along
      if (sx0 < 0) begin dx0 -= sx0; sx0 = 0; end
      if (sy0 < 0) begin dy0 -= sy0; sy0 = 0; end
      if (sx1 >= sw) begin dx1 -= sx1 - sw + 1; sx1 = sw - 1; end
      if (sy1 >= sh) begin dy1 -= sy1 - sh + 1; sy1 = sh - 1; end
      // then the destination frame, dragging the source corners along
      if (dx0 < 0) begin sx0 -= dx0; dx0 = 0; end
      if (dy0 < 0) begin sy0 -= dy0; dy0 = 0; end
      if (dx1 >= dw) begin sx1 -= dx1 - dw + 1; dx1 = dw - 1; end
      if (dy1 >= dh) begin sy1 -= dy1 - dh + 1; dy1 = dh - 1; end
      none_left = (sx1 < 0 || sx0 >= sw || sy1 < 0 || sy0 >= sh) ||
                  (dx1 < 0 || dx0 >= dw || dy1 < 0 || dy0 >= dh) ||
                  (sx0 > sx1 || sy0 > sy1 || dx0 > dx1 || dy0 > dy1);
      if (none_left) begin
        res.is_empty = 1'b1;
        return res;
      end
      res.descending  = !r.dest_below_src;
      res.src_x_first = sx0[DIM_BITS-1:0];
      res.src_y_first = sy0[DIM_BITS-1:0];
      res.src_x_last  = sx1[DIM_BITS-1:0];
      res.src_y_last  = sy1[DIM_BITS-1:0];
      res.dst_x_first = dx0[DIM_BITS-1:0];
      res.dst_y_first = dy0[DIM_BITS-1:0];
      res.dst_x_last  = dx1[DIM_BITS-1:0];
      res.dst_y_last  = dy1[DIM_BITS-1:0];
      // ascending starts at the top-left pixel, descending at the bottom-right
      if (r.dest_below_src) begin
        res.src_ofs = OFS_W'(sy0 * sw + sx0);
        res.dst_ofs = OFS_W'(dy0 * dw + dx0);
      end else begin
        res.src_ofs = OFS_W'(sy1 * sw + sx1);
        res.dst_ofs = OFS_W'(dy1 * dw + dx1);
      end
      return res;
    endfunction

    function void note_request(blit_req_t r);
      pending_q.push_back(clip_rect(r));
    endfunction

    function string show(clip_res_t r);
      return $sformatf({"empty=%0d desc=%0d src=(%0d,%0d)-(%0d,%0d) ",
                        "dst=(%0d,%0d)-(%0d,%0d) src_ofs=%0d dst_ofs=%0d"},
                       r.is_empty, r.descending, r.src_x_first, r.src_y_first,
                       r.src_x_last, r.src_y_last, r.dst_x_first, r.dst_y_first,
                       r.dst_x_last, r.dst_y_last, r.src_ofs, r.dst_ofs);
    endfunction

    function void check_result(logic [M_W-1:0] data);
      clip_res_t got, want;
      got = clip_res_t'(data[RES_W-1:0]);
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no request outstanding: %s", $realtime, show(got));
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block under test
  // --------------------------------------------------------------------------
  logic           clk_i         = 1'b0;
  logic           rst_ni        = 1'b0;
  logic           s_axis_tvalid = 1'b0;
  logic           s_axis_tready;
  logic [S_W-1:0] s_axis_tdata  = '0;  // request fields, dest_stride in the low bits
  logic           m_axis_tvalid;
  logic           m_axis_tready = 1'b0;
  logic [M_W-1:0] m_axis_tdata;        // result fields, empty_res in bit 0

  clip_scoreboard blit_sb = new();

  int unsigned src_idle_pct = 0;  // chance per cycle that the sender idles
  int unsigned rx_idle_pct  = 0;  // chance per cycle that the receiver stalls
  bit          hold_active  = 1'b0;
  int unsigned cycle_count  = 0;
  event        start_hold;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  blit_rectangle_clip_setup #(
    .DIM_BITS(DIM_BITS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Kill a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_blit_rectangle_clip_setup failed");
      $finish;
    end
  end

  // Long receiver hold-off: keep tready low for a fixed stretch so the
  // pipeline fills and the block has to drop s_axis_tready.
  always begin
    @(start_hold);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_active = 1'b0;
  end

  // Receiver: check each accepted result, then pick the next tready.
  always @(posedge clk_i) begin
    if (m_axis_tvalid === 1'b1 && m_axis_tready)
      blit_sb.check_result(m_axis_tdata);
    m_axis_tready <= !hold_active && ($urandom_range(99) >= rx_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Request construction and driving
  // --------------------------------------------------------------------------
  function automatic logic [S_W-1:0] pack_req(blit_req_t r);
    // first field in the low bits; the zero fill above comes from extension
    return S_W'({r.dest_below_src, r.src_pos_y, r.src_pos_x, r.src_rows,
                 r.src_stride, r.rect_h, r.rect_w, r.dst_pos_y, r.dst_pos_x,
                 r.dst_rows, r.dst_stride});
  endfunction

  function automatic blit_req_t mk_req(int dw, int dh, int dx, int dy, int w, int h,
                                       int sw, int sh, int sx, int sy, bit asc);
    blit_req_t r;
    r.dst_stride     = dw[DIM_BITS-1:0];
    r.dst_rows       = dh[DIM_BITS-1:0];
    r.dst_pos_x      = dx[POS_W-1:0];
    r.dst_pos_y      = dy[POS_W-1:0];
    r.rect_w         = w[DIM_BITS-1:0];
    r.rect_h         = h[DIM_BITS-1:0];
    r.src_stride     = sw[DIM_BITS-1:0];
    r.src_rows       = sh[DIM_BITS-1:0];
    r.src_pos_x      = sx[POS_W-1:0];
    r.src_pos_y      = sy[POS_W-1:0];
    r.dest_below_src = asc;
    return r;
  endfunction

  // Mostly plausible requests around the frames (most sizes small so that
  // clips land on every edge), the rest raw bits across the whole field range.
  function automatic blit_req_t rand_request();
    blit_req_t   r;
    int unsigned lim;
    if ($urandom_range(3) == 0) begin
      r = mk_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, 1'($urandom_range(1)));
    end else begin
      lim = ($urandom_range(3) == 0) ? 4095 : 64;
      r.src_stride     = DIM_BITS'($urandom_range(lim, 1));
      r.src_rows       = DIM_BITS'($urandom_range(lim, 1));
      r.dst_stride     = DIM_BITS'($urandom_range(lim, 1));
      r.dst_rows       = DIM_BITS'($urandom_range(lim, 1));
      r.rect_w         = ($urandom_range(19) == 0) ? '0
                         : DIM_BITS'($urandom_range(lim, 1));
      r.rect_h         = ($urandom_range(19) == 0) ? '0
                         : DIM_BITS'($urandom_range(lim, 1));
      r.src_pos_x      = POS_W'(int'($urandom_range(int'(r.src_stride) + int'(r.rect_w)))
                                - int'(r.rect_w));
      r.src_pos_y      = POS_W'(int'($urandom_range(int'(r.src_rows) + int'(r.rect_h)))
                                - int'(r.rect_h));
      r.dst_pos_x      = POS_W'(int'($urandom_range(int'(r.dst_stride) + int'(r.rect_w)))
                                - int'(r.rect_w));
      r.dst_pos_y      = POS_W'(int'($urandom_range(int'(r.dst_rows) + int'(r.rect_h)))
                                - int'(r.rect_h));
      r.dest_below_src = 1'($urandom_range(1));
    end
    return r;
  endfunction

  // Offer one request, idling first at the current rate, and hold it until
  // the block takes it. tvalid stays high for a back-to-back request.
  task automatic send_request(blit_req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_req(r);
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    blit_sb.note_request(r);
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (blit_sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    int unsigned n;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender idles rarely, receiver often
    src_idle_pct = 14;
    rx_idle_pct  = 65;

    // full frame copy, both directions
    send_request(mk_req(64, 48, 0, 0, 64, 48, 64, 48, 0, 0, 1'b1));
    send_request(mk_req(64, 48, 0, 0, 64, 48, 64, 48, 0, 0, 1'b0));
    // zero width, zero height, both
    send_request(mk_req(64, 48, 3, 4, 0, 10, 64, 48, 5, 6, 1'b1));
    send_request(mk_req(64, 48, 3, 4, 10, 0, 64, 48, 5, 6, 1'b0));
    send_request(mk_req(64, 48, 3, 4, 0, 0, 64, 48, 5, 6, 1'b1));
    // negative source position clips left and top of the source
    send_request(mk_req(100, 80, 10, 10, 30, 20, 64, 48, -5, -7, 1'b1));
    // negative destination position clips left and top of the destination
    send_request(mk_req(100, 80, -3, -9, 30, 20, 64, 48, 2, 1, 1'b0));
    // source overflows right and bottom
    send_request(mk_req(100, 80, 5, 5, 20, 20, 64, 48, 60, 40, 1'b1));
    // destination overflows right and bottom
    send_request(mk_req(40, 30, 30, 25, 20, 20, 64, 48, 0, 0, 1'b0));
    // wholly outside the source, wholly outside the destination
    send_request(mk_req(100, 80, 0, 0, 10, 10, 64, 48, 100, 0, 1'b1));
    send_request(mk_req(100, 80, 0, 5000, 10, 10, 64, 48, 0, 0, 1'b1));
    send_request(mk_req(100, 80, 0, 0, 10, 10, 64, 48, -8192, 0, 1'b0));
    // zero stride or zero rows on either frame
    send_request(mk_req(100, 80, 0, 0, 10, 10, 0, 48, 0, 0, 1'b1));
    send_request(mk_req(100, 80, 0, 0, 10, 10, 64, 0, 0, 0, 1'b1));
    send_request(mk_req(0, 80, 0, 0, 10, 10, 64, 48, 0, 0, 1'b0));
    send_request(mk_req(100, 0, 0, 0, 10, 10, 64, 48, 0, 0, 1'b0));
    // largest frames and rectangle, descending for the biggest offsets
    send_request(mk_req(4095, 4095, 0, 0, 4095, 4095, 4095, 4095, 0, 0, 1'b0));
    send_request(mk_req(4095, 4095, 8191, 8191, 4095, 4095, 4095, 4095, 8191, 8191,
                        1'b1));
    // single pixel at the far corner, and in a one-pixel frame
    send_request(mk_req(4095, 4095, 4094, 4094, 1, 1, 4095, 4095, 4094, 4094, 1'b0));
    send_request(mk_req(1, 1, 0, 0, 1, 1, 1, 1, 0, 0, 1'b1));
    // clipped on all four sides by the source frame, then emptied by the destination frame
    send_request(mk_req(50, 40, -50, -30, 4095, 4095, 70, 60, -100, -20, 1'b0));
    // every field all ones
    send_request(mk_req(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, 1'b1));

    for (n = 0; n < PHASE_ITEMS; n++) begin
      if (n == 40)
        -> start_hold;
      send_request(rand_request());
    end
    drain_results();

    // sender idles often, receiver rarely
    src_idle_pct = 65;
    rx_idle_pct  = 14;
    for (n = 0; n < PHASE_ITEMS; n++) begin
      if (n == 100)
        drain_results();
      send_request(rand_request());
    end
    drain_results();

    // full rate both ways
    src_idle_pct = 0;
    rx_idle_pct  = 0;
    for (n = 0; n < PHASE_ITEMS; n++)
      send_request(rand_request());
    drain_results();

    // let any stray result show up before the verdict
    repeat (4 * PIPE_STAGES) @(posedge clk_i);
    if (blit_sb.mismatches == 0 && blit_sb.pending_q.size() == 0) begin
      $display("tb_blit_rectangle_clip_setup passed");
    end else begin
      $display("tb_blit_rectangle_clip_setup failed");
    end
    $finish;
  end

endmodule

@@ blit_rectangle_clip_setup.f @@
hdl/brcs_pkg.sv
hdl/blit_rectangle_clip_setup.sv
hdl/brcs_checker.sv
tb/tb_blit_rectangle_clip_setup.sv
